// ----- sv/irrft_pkg.sv -----
// Package for the IR remote frame transmitter: item structs, phase
// encoding, register indexes and register reset values.
// No dependencies.
`default_nettype none

package irrft_pkg;

  // Input item: func selects load or tick
  typedef struct packed {
    logic       func;
    logic [7:0] device_address;
    logic [7:0] command_code;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic load_accepted;
  } out_item_t;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_HDR_PULSE  = 3'd0;
  localparam logic [2:0] REG_HDR_PAUSE  = 3'd1;
  localparam logic [2:0] REG_FIRST_PER  = 3'd2;
  localparam logic [2:0] REG_REPEAT_PER = 3'd3;
  localparam logic [2:0] REG_REPEAT_CNT = 3'd4;

  // Register reset values
  localparam logic [5:0] HDR_PULSE_RST  = 6'd16;
  localparam logic [5:0] HDR_PAUSE_RST  = 6'd8;
  localparam logic [7:0] FIRST_PER_RST  = 8'd88;
  localparam logic [7:0] REPEAT_PER_RST = 8'd81;
  localparam logic [2:0] REPEAT_CNT_RST = 3'd3;

  // Pause slots that encode a one bit
  localparam logic [5:0] ONE_PAUSE_SLOTS = 6'd3;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_HDR_PULSE = 7'b0000010,
    PH_HDR_PAUSE = 7'b0000100,
    PH_BIT_PULSE = 7'b0001000,
    PH_BIT_PAUSE = 7'b0010000,
    PH_STOP      = 7'b0100000,
    PH_GAP       = 7'b1000000
  } phase_t;

endpackage

`default_nettype wire

// ----- sv/ir_remote_frame_transmitter.sv -----
// IR remote frame transmitter top level: slot sequencer, configuration
// registers and a two-entry result buffer.
// Depends on irrft_pkg.
//
// Usage: send a load item (func 0) with an address and a command byte while
// the block is idle; it starts a pulse-distance frame. Each tick item
// (func 1) then advances one modulation slot: header pulse, header pause,
// PAYLOAD_BITS data bits MSB first (pulse plus one pause for 0, pulse plus
// three pauses for 1), a stop pulse, low padding to the frame period, and
// repeat_count headerless repeats. Every item yields exactly one result item
// with the level, busy and load-accepted flags.
// Throughput is one item per cycle while in_stall is low; a result is
// registered into out_r, or into the skid register while out_r is stalled.
// The sequencer updates all state in the same cycle the item is taken.
// When the receiver stalls, the output register holds its item and one more
// result goes to a skid register; in_stall rises only while that skid entry
// is full. Configuration writes are taken every cycle (cfg_ready is high)
// and should be issued while idle.
// Reset (rst_n low, synchronous) returns to idle with level low, empties
// the result buffer and restores the register defaults.
`default_nettype none

module ir_remote_frame_transmitter #(
  parameter int PAYLOAD_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  irrft_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output irrft_pkg::out_item_t out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [2:0]           cfg_index,
  input  wire  [7:0]           cfg_data
);
  import irrft_pkg::*;

  localparam int IDXW = (PAYLOAD_BITS > 1) ? $clog2(PAYLOAD_BITS) : 1;
  localparam int CNTW = $clog2(PAYLOAD_BITS + 1);

  // Configuration registers
  logic [5:0] hdr_pulse_r;
  logic [5:0] hdr_pause_r;
  logic [7:0] first_per_r;
  logic [7:0] repeat_per_r;
  logic [2:0] repeat_cnt_r;

  // Sequencer state
  logic                    active_r,  active_nxt;
  logic [PAYLOAD_BITS-1:0] payload_r, payload_nxt;
  phase_t                  phase_r,   phase_nxt;
  logic [5:0]              slot_r,    slot_nxt;
  logic [CNTW-1:0]         bidx_r,    bidx_nxt;
  logic [2:0]              reps_r,    reps_nxt;
  logic [8:0]              per_r,     per_nxt;
  logic                    level_r,   level_nxt;

  // Result buffer
  out_item_t res;
  out_item_t out_r;
  out_item_t skid_r;
  logic      out_v_r;
  logic      skid_v_r;

  logic            accept;
  logic            out_take;
  logic [8:0]      per_dec;
  logic [5:0]      slot_inc;
  logic [CNTW-1:0] bidx_inc;
  logic [CNTW-1:0] pos_full;
  logic            cur_bit;
  logic [15:0]     raw_payload;
  logic            accepted;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_v_r;
  assign accept    = in_valid && !skid_v_r;
  assign out_take  = out_v_r && !out_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pulse_r  <= HDR_PULSE_RST;
      hdr_pause_r  <= HDR_PAUSE_RST;
      first_per_r  <= FIRST_PER_RST;
      repeat_per_r <= REPEAT_PER_RST;
      repeat_cnt_r <= REPEAT_CNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HDR_PULSE:  hdr_pulse_r  <= cfg_data[5:0];
        REG_HDR_PAUSE:  hdr_pause_r  <= cfg_data[5:0];
        REG_FIRST_PER:  first_per_r  <= cfg_data;
        REG_REPEAT_PER: repeat_per_r <= cfg_data;
        REG_REPEAT_CNT: repeat_cnt_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign per_dec     = (per_r == 9'd0) ? 9'd0 : per_r - 9'd1;
  assign slot_inc    = slot_r + 6'd1;
  assign bidx_inc    = bidx_r + CNTW'(1);
  assign pos_full    = CNTW'(PAYLOAD_BITS - 1) - bidx_r;
  assign cur_bit     = payload_r[pos_full[IDXW-1:0]];
  assign raw_payload = {in_data.device_address, in_data.command_code};

  always_comb begin
    active_nxt  = active_r;
    payload_nxt = payload_r;
    phase_nxt   = phase_r;
    slot_nxt    = slot_r;
    bidx_nxt    = bidx_r;
    reps_nxt    = reps_r;
    per_nxt     = per_r;
    level_nxt   = level_r;
    accepted    = 1'b0;

    if (in_data.func == FUNC_LOAD) begin
      if (!active_r) begin
        active_nxt  = 1'b1;
        payload_nxt = PAYLOAD_BITS'(raw_payload);
        phase_nxt   = PH_HDR_PULSE;
        slot_nxt    = 6'd0;
        bidx_nxt    = '0;
        reps_nxt    = 3'd0;
        per_nxt     = {1'b0, first_per_r} + {3'b000, hdr_pulse_r} + {3'b000, hdr_pause_r};
        level_nxt   = 1'b0;
        accepted    = 1'b1;
      end
    end else if (active_r) begin
      unique case (phase_r)
        PH_HDR_PULSE: begin
          per_nxt   = per_dec;
          level_nxt = 1'b1;
          slot_nxt  = slot_inc;
          // a zero count counts as one slot
          if (slot_inc == 6'd0 || slot_inc >= hdr_pulse_r) begin
            phase_nxt = PH_HDR_PAUSE;
            slot_nxt  = 6'd0;
          end
        end
        PH_HDR_PAUSE: begin
          per_nxt   = per_dec;
          level_nxt = 1'b0;
          slot_nxt  = slot_inc;
          if (slot_inc == 6'd0 || slot_inc >= hdr_pause_r) begin
            phase_nxt = PH_BIT_PULSE;
            slot_nxt  = 6'd0;
            bidx_nxt  = '0;
          end
        end
        PH_BIT_PULSE: begin
          per_nxt   = per_dec;
          level_nxt = 1'b1;
          phase_nxt = PH_BIT_PAUSE;
          slot_nxt  = 6'd0;
        end
        PH_BIT_PAUSE: begin
          per_nxt   = per_dec;
          level_nxt = 1'b0;
          slot_nxt  = slot_inc;
          if (slot_inc >= (cur_bit ? ONE_PAUSE_SLOTS : 6'd1)) begin
            slot_nxt  = 6'd0;
            bidx_nxt  = bidx_inc;
            phase_nxt = (bidx_inc >= CNTW'(PAYLOAD_BITS)) ? PH_STOP : PH_BIT_PULSE;
          end
        end
        PH_STOP: begin
          per_nxt   = per_dec;
          level_nxt = 1'b1;
          phase_nxt = PH_GAP;
        end
        PH_GAP: begin
          level_nxt = 1'b0;
          if (reps_r < repeat_cnt_r) begin
            per_nxt = per_dec;
            // start the next repeat once the period has run out
            if (per_dec == 9'd0) begin
              phase_nxt = PH_BIT_PULSE;
              bidx_nxt  = '0;
              slot_nxt  = 6'd0;
              reps_nxt  = reps_r + 3'd1;
              per_nxt   = {1'b0, repeat_per_r};
            end
          end else begin
            active_nxt = 1'b0;
            phase_nxt  = PH_IDLE;
          end
        end
        default: begin
          active_nxt = 1'b0;
          phase_nxt  = PH_IDLE;
        end
      endcase
    end

    res.ir_level      = level_nxt;
    res.busy_res      = active_nxt;
    res.load_accepted = accepted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r  <= PH_IDLE;
      slot_r   <= 6'd0;
      bidx_r   <= '0;
      reps_r   <= 3'd0;
      per_r    <= 9'd0;
      level_r  <= 1'b0;
      payload_r <= '0;
    end else if (accept) begin
      active_r  <= active_nxt;
      phase_r   <= phase_nxt;
      slot_r    <= slot_nxt;
      bidx_r    <= bidx_nxt;
      reps_r    <= reps_nxt;
      per_r     <= per_nxt;
      level_r   <= level_nxt;
      payload_r <= payload_nxt;
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_take) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= accept;
      end else begin
        out_v_r  <= accept;
      end
    end else if (accept) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_take) begin
      if (skid_v_r) begin
        out_r  <= skid_r;
        skid_r <= res;
      end else begin
        out_r  <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- tb/ir_remote_frame_transmitter_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the IR remote frame transmitter: drives load and
// tick items, mirrors the slot sequencer in a shadow model and checks every result.
// Depends on irrft_pkg and ir_remote_frame_transmitter.

module ir_remote_frame_transmitter_tb;
  import irrft_pkg::*;

  localparam int PAYLOAD_BITS = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam int ITEMS_PER_SETTING = 88;
  localparam int PRINT_LIMIT = 40;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  ir_remote_frame_transmitter #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the transmitter state and its registers
  logic        tx_active;
  logic [15:0] tx_payload;
  phase_t      tx_phase;
  logic [5:0]  tx_slot;
  logic [4:0]  tx_bit;
  logic [2:0]  tx_repeats;
  logic [8:0]  tx_period;
  logic        tx_level;
  logic [5:0]  hdr_pulse_reg;
  logic [5:0]  hdr_pause_reg;
  logic [7:0]  first_period_reg;
  logic [7:0]  repeat_period_reg;
  logic [2:0]  repeat_count_reg;

  out_item_t pending_results[$];
  out_item_t oldest_result;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned items_worked = 0;
  int unsigned reg_writes = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  function automatic void count_down();
    if (tx_period != 9'd0) tx_period = tx_period - 9'd1;
  endfunction

  function automatic logic bit_now();
    if (tx_bit >= PAYLOAD_BITS) return 1'b0;
    return tx_payload[PAYLOAD_BITS - 1 - int'(tx_bit)];
  endfunction

  // Advance the shadow by one modulation slot
  function automatic void step_slot();
    case (tx_phase)
      PH_HDR_PULSE: begin
        count_down();
        tx_level = 1'b1;
        tx_slot = tx_slot + 6'd1;
        if (tx_slot == 6'd0 || tx_slot >= hdr_pulse_reg) begin
          tx_phase = PH_HDR_PAUSE;
          tx_slot = '0;
        end
      end
      PH_HDR_PAUSE: begin
        count_down();
        tx_level = 1'b0;
        tx_slot = tx_slot + 6'd1;
        if (tx_slot == 6'd0 || tx_slot >= hdr_pause_reg) begin
          tx_phase = PH_BIT_PULSE;
          tx_slot = '0;
          tx_bit = '0;
        end
      end
      PH_BIT_PULSE: begin
        count_down();
        tx_level = 1'b1;
        tx_phase = PH_BIT_PAUSE;
        tx_slot = '0;
      end
      PH_BIT_PAUSE: begin
        count_down();
        tx_level = 1'b0;
        tx_slot = tx_slot + 6'd1;
        if (tx_slot >= (bit_now() ? ONE_PAUSE_SLOTS : 6'd1)) begin
          tx_slot = '0;
          tx_bit = tx_bit + 5'd1;
          tx_phase = (tx_bit >= PAYLOAD_BITS) ? PH_STOP : PH_BIT_PULSE;
        end
      end
      PH_STOP: begin
        count_down();
        tx_level = 1'b1;
        tx_phase = PH_GAP;
      end
      PH_GAP: begin
        tx_level = 1'b0;
        if (tx_repeats < repeat_count_reg) begin
          count_down();
          // next repeat starts once the padding has used up the period
          if (tx_period == 9'd0) begin
            tx_phase = PH_BIT_PULSE;
            tx_bit = '0;
            tx_slot = '0;
            tx_repeats = tx_repeats + 3'd1;
            tx_period = {1'b0, repeat_period_reg};
          end
        end else begin
          tx_active = 1'b0;
          tx_phase = PH_IDLE;
        end
      end
      default: begin
        tx_active = 1'b0;
        tx_phase = PH_IDLE;
      end
    endcase
  endfunction

  function automatic out_item_t predict_result(in_item_t item);
    out_item_t res;
    res.load_accepted = 1'b0;
    if (item.func == FUNC_LOAD) begin
      if (!tx_active) begin
        tx_active = 1'b1;
        tx_payload = {item.device_address, item.command_code};
        tx_phase = PH_HDR_PULSE;
        tx_slot = '0;
        tx_bit = '0;
        tx_repeats = '0;
        tx_period = 9'(first_period_reg) + 9'(hdr_pulse_reg) + 9'(hdr_pause_reg);
        tx_level = 1'b0;
        res.load_accepted = 1'b1;
      end
    end else if (tx_active) begin
      step_slot();
    end
    res.ir_level = tx_level;
    res.busy_res = tx_active;
    return res;
  endfunction

  function automatic void reset_shadow();
    tx_active = 1'b0;
    tx_payload = '0;
    tx_phase = PH_IDLE;
    tx_slot = '0;
    tx_bit = '0;
    tx_repeats = '0;
    tx_period = '0;
    tx_level = 1'b0;
    hdr_pulse_reg = HDR_PULSE_RST;
    hdr_pause_reg = HDR_PAUSE_RST;
    first_period_reg = FIRST_PER_RST;
    repeat_period_reg = REPEAT_PER_RST;
    repeat_count_reg = REPEAT_CNT_RST;
  endfunction

  function automatic in_item_t make_item(logic func, logic [7:0] addr, logic [7:0] cmd);
    in_item_t item;
    item.func = func;
    item.device_address = addr;
    item.command_code = cmd;
    return item;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Result checker; also drives the receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.ir_level !== oldest_result.ir_level)
          report_mismatch($sformatf("ir_level %b, want %b", out_data.ir_level,
                                    oldest_result.ir_level));
        if (out_data.busy_res !== oldest_result.busy_res)
          report_mismatch($sformatf("busy_res %b, want %b", out_data.busy_res,
                                    oldest_result.busy_res));
        if (out_data.load_accepted !== oldest_result.load_accepted)
          report_mismatch($sformatf("load_accepted %b, want %b", out_data.load_accepted,
                                    oldest_result.load_accepted));
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the item was taken or after a gap
  task automatic send_item(input in_item_t item);
    logic worked;
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    worked = (item.func == FUNC_TICK) ? tx_active : !tx_active;
    pending_results.push_back(predict_result(item));
    items_sent++;
    if (worked) items_worked++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_tick();
    send_item(make_item(FUNC_TICK, 8'($urandom_range(255)), 8'($urandom_range(255))));
  endtask

  task automatic run_to_idle();
    while (tx_active) send_tick();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      REG_HDR_PULSE:  hdr_pulse_reg = value[5:0];
      REG_HDR_PAUSE:  hdr_pause_reg = value[5:0];
      REG_FIRST_PER:  first_period_reg = value;
      REG_REPEAT_PER: repeat_period_reg = value;
      REG_REPEAT_CNT: repeat_count_reg = value[2:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] hp, input logic [7:0] hs, input logic [7:0] fp,
                            input logic [7:0] rp, input logic [7:0] rc);
    write_reg(REG_HDR_PULSE, hp);
    write_reg(REG_HDR_PAUSE, hs);
    write_reg(REG_FIRST_PER, fp);
    write_reg(REG_REPEAT_PER, rp);
    write_reg(REG_REPEAT_CNT, rc);
  endtask

  task automatic test_idle_ticks();
    send_item(make_item(FUNC_TICK, 8'h00, 8'h00));
    send_item(make_item(FUNC_TICK, 8'hFF, 8'hFF));
    wait_drained();
  endtask

  // Reset register values: one frame plus three repeats
  task automatic test_default_frame();
    send_item(make_item(FUNC_LOAD, 8'hA5, 8'h3C));
    send_item(make_item(FUNC_LOAD, 8'hFF, 8'hFF));
    send_tick();
    send_item(make_item(FUNC_LOAD, 8'h00, 8'h00));
    run_to_idle();
    wait_drained();
  endtask

  // Zero header counts and zero periods: frames overrun their period
  task automatic test_zero_settings();
    set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd2);
    send_item(make_item(FUNC_LOAD, 8'h00, 8'hFF));
    run_to_idle();
    send_item(make_item(FUNC_LOAD, 8'hFF, 8'h00));
    run_to_idle();
    wait_drained();
  endtask

  // Shrink the header while it is being sent; unused index must be ignored
  task automatic test_midframe_write();
    set_config(8'd20, 8'd4, 8'd10, 8'd5, 8'd1);
    write_reg(REG_UNUSED, 8'hFF);
    send_item(make_item(FUNC_LOAD, 8'h12, 8'h34));
    repeat (5) send_tick();
    wait_drained();
    write_reg(REG_HDR_PULSE, 8'd2);
    run_to_idle();
    wait_drained();
  endtask

  // Largest settings, then drop the repeat count below the repeats already sent
  task automatic test_max_settings();
    set_config(8'd63, 8'd63, 8'd255, 8'd255, 8'd7);
    send_item(make_item(FUNC_LOAD, 8'hFF, 8'hFF));
    while (tx_repeats == 3'd0) send_tick();
    repeat (10) send_tick();
    wait_drained();
    write_reg(REG_REPEAT_CNT, 8'd0);
    run_to_idle();
    wait_drained();
  endtask

  function automatic logic [7:0] pick_value(int unsigned lo, int unsigned hi, int unsigned typ);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'(lo);
    if (r == 1) return 8'(hi);
    return 8'($urandom_range(typ, lo));
  endfunction

  task automatic random_config();
    // upper bits above a narrow register's width are junk and must be dropped
    set_config(pick_value(0, 63, 6) | 8'($urandom_range(3) << 6),
               pick_value(0, 63, 6) | 8'($urandom_range(3) << 6),
               pick_value(0, 255, 40),
               pick_value(0, 255, 40),
               8'($urandom_range(7)) | 8'($urandom_range(31) << 3));
  endtask

  task automatic run_random_items(input int unsigned count);
    int unsigned start;
    logic func;
    start = items_worked;
    while (items_worked - start < count) begin
      if (!tx_active) func = ($urandom_range(9) < 7) ? FUNC_LOAD : FUNC_TICK;
      else func = ($urandom_range(99) < 3) ? FUNC_LOAD : FUNC_TICK;
      send_item(make_item(func, 8'($urandom_range(255)), 8'($urandom_range(255))));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned idle_plan[4] = '{0, 64, 0, 8};
    int unsigned stall_plan[4] = '{0, 0, 64, 8};
    for (int m = 0; m < 4; m++) begin
      send_idle_pct = idle_plan[m];
      stall_pct = stall_plan[m];
      repeat (2) begin
        random_config();
        run_random_items(ITEMS_PER_SETTING);
        wait_drained();
      end
    end
  endtask

  initial begin
    reset_shadow();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 10;
    stall_pct = 10;
    test_idle_ticks();
    test_default_frame();
    test_zero_settings();
    test_midframe_write();
    test_max_settings();
    test_random_traffic();
    wait_drained();
    $display("tb: %0d items sent (%0d moved the sequencer), %0d register writes",
             items_sent, items_worked, reg_writes);
    $display("tb: %0d results checked, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
